// ===== rtl/core/pidr_pkg.sv =====
// Shared types, widths and default constants for the ramped position PID block.
// Used by every module under rtl/core; no dependencies.

package pidr_pkg;

  localparam int POS_W      = 24;
  localparam int ERR_W      = POS_W + 1;
  localparam int DER_W      = ERR_W + 1;
  localparam int INT_W      = 32;
  localparam int SPD_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int MS_W       = 16;
  localparam int ZONE_W     = 23;
  localparam int MAXS_W     = 15;
  localparam int RAMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int I_W   = GAIN_W + 1 + INT_W;
  localparam int D_W   = GAIN_W + 1 + DER_W;
  localparam int SUM_W = I_W;
  localparam int SHR_W = SUM_W - 8;

  localparam int unsigned MIN_SPEED_DEF       = 256;
  localparam int unsigned ERROR_THRESHOLD_DEF = 32;
  localparam int unsigned DERIV_THRESHOLD_DEF = 1;
  localparam int unsigned INTEGRAL_LIMIT_DEF  = 1073741823;
  localparam int unsigned RAMP_START_DEF      = 640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_POSITION = 3'd0,
    REG_MAX_SPEED       = 3'd1,
    REG_GAIN_P          = 3'd2,
    REG_GAIN_I          = 3'd3,
    REG_GAIN_D          = 3'd4,
    REG_TIMEOUT_MS      = 3'd5,
    REG_INTEGRAL_ZONE   = 3'd6,
    REG_RAMP_STEP       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target_position;
    logic [MAXS_W-1:0]       max_speed;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [MS_W-1:0]         timeout_ms;
    logic [ZONE_W-1:0]       integral_zone;
    logic [MAXS_W-1:0]       ramp_step;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] integ;
    logic signed [DER_W-1:0] deriv;
    logic                    ramp_on;
    logic [RAMP_W-1:0]       ramp_lim;
    logic                    settled;
    logic                    timed_out;
  } trk_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [I_W-1:0] i;
    logic signed [D_W-1:0] d;
    logic                  ramp_on;
    logic [RAMP_W-1:0]     ramp_lim;
    logic                  settled;
    logic                  timed_out;
  } prod_t;

endpackage

// ===== rtl/core/pidr_track.sv =====
// Input register and error stage: error, clamped integral, derivative, ramp limit, flags.
// Holds the controller state. Depends on pidr_pkg.

module pidr_track import pidr_pkg::*; #(
  parameter int unsigned ERROR_THRESHOLD = ERROR_THRESHOLD_DEF,
  parameter int unsigned DERIV_THRESHOLD = DERIV_THRESHOLD_DEF,
  parameter int unsigned INTEGRAL_LIMIT  = INTEGRAL_LIMIT_DEF,
  parameter int unsigned RAMP_START      = RAMP_START_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_measured_position,
  input  logic [MS_W-1:0]         in_elapsed_ms,
  input  logic                    in_start_move,
  output logic                    trk_valid,
  input  logic                    trk_ready,
  output trk_t                    trk
);

  logic                    v0_r;
  logic signed [POS_W-1:0] meas_r;
  logic [MS_W-1:0]         ms_r;
  logic                    start_r;
  logic                    v1_r;
  trk_t                    trk_r;
  trk_t                    trk_nxt;

  logic signed [INT_W-1:0] integral_sum_r;
  logic signed [ERR_W-1:0] prev_err_r;
  logic [RAMP_W-1:0]       ramp_limit_r;
  logic [RAMP_W-1:0]       ramp_limit_nxt;

  logic                    adv1;
  logic                    ready0;
  logic signed [INT_W-1:0] base_int;
  logic signed [ERR_W-1:0] base_prev;
  logic [RAMP_W-1:0]       base_ramp;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_mag;
  logic signed [INT_W:0]   int_sum;
  logic signed [INT_W:0]   int_lim;
  logic signed [INT_W-1:0] int_new;
  logic signed [DER_W-1:0] deriv;
  logic [DER_W-1:0]        deriv_mag;
  logic [RAMP_W:0]         ramp_sum;
  logic [RAMP_W-1:0]       ramp_sat;
  logic                    ramp_on;

  assign adv1     = v0_r && (!v1_r || trk_ready);
  assign ready0   = !v0_r || adv1;
  assign in_ready = ready0;

  assign base_int  = start_r ? '0 : integral_sum_r;
  assign base_prev = start_r ? '0 : prev_err_r;
  assign base_ramp = start_r ? RAMP_W'(RAMP_START) : ramp_limit_r;

  assign err     = ERR_W'(cfg.target_position) - ERR_W'(meas_r);
  assign err_mag = err[ERR_W-1] ? $unsigned(-err) : $unsigned(err);
  assign int_sum = (INT_W+1)'(base_int) + (INT_W+1)'(err);
  assign int_lim = $signed((INT_W+1)'(INTEGRAL_LIMIT));

  always_comb begin
    if (err_mag > ERR_W'(cfg.integral_zone)) begin
      int_new = '0;
    end else if (int_sum > int_lim) begin
      int_new = INT_W'(int_lim);
    end else if (int_sum < -int_lim) begin
      int_new = INT_W'(-int_lim);
    end else begin
      int_new = INT_W'(int_sum);
    end
  end

  assign deriv     = DER_W'(err) - DER_W'(base_prev);
  assign deriv_mag = deriv[DER_W-1] ? $unsigned(-deriv) : $unsigned(deriv);

  assign ramp_on        = cfg.ramp_step != '0;
  assign ramp_sum       = (RAMP_W+1)'(base_ramp) + (RAMP_W+1)'(cfg.ramp_step);
  assign ramp_sat       = ramp_sum[RAMP_W] ? '1 : ramp_sum[RAMP_W-1:0];
  assign ramp_limit_nxt = ramp_on ? ramp_sat : base_ramp;

  always_comb begin
    trk_nxt.err       = err;
    trk_nxt.integ     = int_new;
    trk_nxt.deriv     = deriv;
    trk_nxt.ramp_on   = ramp_on;
    trk_nxt.ramp_lim  = ramp_limit_nxt;
    trk_nxt.settled   = (err_mag < ERR_W'(ERROR_THRESHOLD)) &&
                        (deriv_mag <= DER_W'(DERIV_THRESHOLD));
    trk_nxt.timed_out = (cfg.timeout_ms != '0) && (ms_r > cfg.timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r           <= 1'b0;
      v1_r           <= 1'b0;
      integral_sum_r <= '0;
      prev_err_r     <= '0;
      ramp_limit_r   <= RAMP_W'(RAMP_START);
    end else begin
      if (ready0) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r           <= 1'b1;
        integral_sum_r <= int_new;
        prev_err_r     <= err;
        ramp_limit_r   <= ramp_limit_nxt;
      end else if (trk_ready) begin
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready0) begin
      meas_r  <= in_measured_position;
      ms_r    <= in_elapsed_ms;
      start_r <= in_start_move;
    end
    if (adv1) begin
      trk_r <= trk_nxt;
    end
  end

  assign trk_valid = v1_r;
  assign trk       = trk_r;

endmodule

// ===== rtl/core/pidr_mult.sv =====
// Gain stage: the three gain products, registered.
// Depends on pidr_pkg.

module pidr_mult import pidr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  trk_valid,
  output logic  trk_ready,
  input  trk_t  trk,
  output logic  prod_valid,
  input  logic  prod_ready,
  output prod_t prod
);

  logic  v_r;
  prod_t prod_r;
  prod_t prod_nxt;
  logic  adv;

  assign adv       = trk_valid && (!v_r || prod_ready);
  assign trk_ready = !v_r || prod_ready;

  always_comb begin
    prod_nxt.p         = $signed({1'b0, cfg.gain_p}) * trk.err;
    prod_nxt.i         = $signed({1'b0, cfg.gain_i}) * trk.integ;
    prod_nxt.d         = $signed({1'b0, cfg.gain_d}) * trk.deriv;
    prod_nxt.ramp_on   = trk.ramp_on;
    prod_nxt.ramp_lim  = trk.ramp_lim;
    prod_nxt.settled   = trk.settled;
    prod_nxt.timed_out = trk.timed_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= 1'b1;
    end else if (prod_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = v_r;
  assign prod       = prod_r;

endmodule

// ===== rtl/core/pidr_shape.sv =====
// Output stage: sum, floor shift, ramp and maximum clamps, minimum-speed floor.
// Holds the result register. Depends on pidr_pkg.

module pidr_shape import pidr_pkg::*; #(
  parameter int unsigned MIN_SPEED = MIN_SPEED_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    prod_valid,
  output logic                    prod_ready,
  input  prod_t                   prod,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SPD_W-1:0] out_drive_speed,
  output logic                    out_settled,
  output logic                    out_timed_out
);

  logic                    v_r;
  logic signed [SPD_W-1:0] speed_r;
  logic                    settled_r;
  logic                    timed_r;
  logic                    adv;

  logic signed [SUM_W-1:0] sum;
  logic signed [SHR_W-1:0] spd0;
  logic signed [SHR_W-1:0] spd1;
  logic signed [SHR_W-1:0] spd2;
  logic signed [SHR_W-1:0] spd3;
  logic signed [SHR_W-1:0] rl;
  logic signed [SHR_W-1:0] ml;
  logic signed [SHR_W-1:0] mn;

  assign adv        = prod_valid && (!v_r || out_ready);
  assign prod_ready = !v_r || out_ready;

  assign sum  = SUM_W'(prod.p) + prod.i + SUM_W'(prod.d);
  assign spd0 = SHR_W'(sum >>> 8);
  assign rl   = $signed(SHR_W'(prod.ramp_lim));
  assign ml   = $signed(SHR_W'(cfg.max_speed));
  assign mn   = $signed(SHR_W'(MIN_SPEED));

  always_comb begin
    spd1 = spd0;
    if (prod.ramp_on) begin
      if (spd0 > rl) begin
        spd1 = rl;
      end else if (spd0 < -rl) begin
        spd1 = -rl;
      end
    end
    spd2 = spd1;
    if (spd1 > ml) begin
      spd2 = ml;
    end else if (spd1 < -ml) begin
      spd2 = -ml;
    end
    spd3 = spd2;
    if (spd2 > 0 && spd2 < mn) begin
      spd3 = mn;
    end else if (spd2 < 0 && spd2 > -mn) begin
      spd3 = -mn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= 1'b1;
    end else if (out_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      speed_r   <= spd3[SPD_W-1:0];
      settled_r <= prod.settled;
      timed_r   <= prod.timed_out;
    end
  end

  assign out_valid       = v_r;
  assign out_drive_speed = speed_r;
  assign out_settled     = settled_r;
  assign out_timed_out   = timed_r;

endmodule

// ===== rtl/core/pid_position_with_ramp.sv =====
// Top level of the ramped position PID: configuration registers and the stage chain.
// Depends on pidr_pkg, pidr_track, pidr_mult and pidr_shape.
//
// Usage:
//   One input beat per control tick: measured position (Q.8), elapsed ms and
//   a start flag that first clears integral and last error and resets ramp limit.
//   One result beat per tick: drive speed (Q8.8), settled and timed-out flags.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index; the user must
//   write only while the block is idle, which the block itself does not enforce.
//   Path: a taken input beat passes the input, error, gain and output registers.
//   Throughput: one beat per cycle while no stage stalls; the controller state
//   updates in the error stage, so the next tick may follow directly.
//   Stalls: each stage holds its beat while the next is full; in_ready stays
//   high as long as any stage of the chain has room, and is always high while
//   no result is waiting.
//   Reset (rst_n low at a clock edge): all stages empty, integral and last
//   error zero, ramp limit at its start value, registers at their defaults.

module pid_position_with_ramp import pidr_pkg::*; #(
  parameter int unsigned MIN_SPEED       = MIN_SPEED_DEF,
  parameter int unsigned ERROR_THRESHOLD = ERROR_THRESHOLD_DEF,
  parameter int unsigned DERIV_THRESHOLD = DERIV_THRESHOLD_DEF,
  parameter int unsigned INTEGRAL_LIMIT  = INTEGRAL_LIMIT_DEF,
  parameter int unsigned RAMP_START      = RAMP_START_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_measured_position,
  input  logic [MS_W-1:0]         in_elapsed_ms,
  input  logic                    in_start_move,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SPD_W-1:0] out_drive_speed,
  output logic                    out_settled,
  output logic                    out_timed_out
);

  cfg_t  cfg_r;
  logic  trk_valid;
  logic  trk_ready;
  trk_t  trk;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_position <= '0;
      cfg_r.max_speed       <= MAXS_W'(25600);
      cfg_r.gain_p          <= GAIN_W'(2304);
      cfg_r.gain_i          <= '0;
      cfg_r.gain_d          <= GAIN_W'(1024);
      cfg_r.timeout_ms      <= '0;
      cfg_r.integral_zone   <= ZONE_W'(1280);
      cfg_r.ramp_step       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_TARGET_POSITION: cfg_r.target_position <= $signed(cfg_wdata[POS_W-1:0]);
        REG_MAX_SPEED:       cfg_r.max_speed       <= cfg_wdata[MAXS_W-1:0];
        REG_GAIN_P:          cfg_r.gain_p          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:          cfg_r.gain_i          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:          cfg_r.gain_d          <= cfg_wdata[GAIN_W-1:0];
        REG_TIMEOUT_MS:      cfg_r.timeout_ms      <= cfg_wdata[MS_W-1:0];
        REG_INTEGRAL_ZONE:   cfg_r.integral_zone   <= cfg_wdata[ZONE_W-1:0];
        REG_RAMP_STEP:       cfg_r.ramp_step       <= cfg_wdata[MAXS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pidr_track #(
    .ERROR_THRESHOLD (ERROR_THRESHOLD),
    .DERIV_THRESHOLD (DERIV_THRESHOLD),
    .INTEGRAL_LIMIT  (INTEGRAL_LIMIT),
    .RAMP_START      (RAMP_START)
  ) u_track (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measured_position (in_measured_position),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_start_move        (in_start_move),
    .trk_valid            (trk_valid),
    .trk_ready            (trk_ready),
    .trk                  (trk)
  );

  pidr_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .trk_valid  (trk_valid),
    .trk_ready  (trk_ready),
    .trk        (trk),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  pidr_shape #(
    .MIN_SPEED (MIN_SPEED)
  ) u_shape (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .prod_valid      (prod_valid),
    .prod_ready      (prod_ready),
    .prod            (prod),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_speed (out_drive_speed),
    .out_settled     (out_settled),
    .out_timed_out   (out_timed_out)
  );

endmodule

// ===== rtl/core/pidr_chk.sv =====
// Port-level checker for the ramped position PID, bound to the top level.
// Depends on pidr_pkg.

module pidr_chk import pidr_pkg::*; #(
  parameter int unsigned MIN_SPEED = MIN_SPEED_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SPD_W-1:0] out_drive_speed,
  input logic                    out_settled,
  input logic                    out_timed_out
);

  localparam logic signed [SPD_W:0] MIN_S = $signed((SPD_W+1)'(MIN_SPEED));

  logic signed [SPD_W:0] spd_x;
  assign spd_x = (SPD_W+1)'(out_drive_speed);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_speed) &&
      $stable(out_settled) && $stable(out_timed_out))
    else $error("stalled result beat changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_min_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_speed != 0 |-> spd_x >= MIN_S || spd_x <= -MIN_S)
    else $error("nonzero speed below minimum");

endmodule

bind pid_position_with_ramp pidr_chk #(.MIN_SPEED(MIN_SPEED)) u_pidr_chk (.*);
